[hdl/elx_pkg.sv]
// ----------------------------------------------------------------------------
// elx_pkg
// Shared types, character codes and tables of the expression lexer.
// ----------------------------------------------------------------------------
package elx_pkg;

  localparam int FRAC_DIGITS_DEF = 10;
  localparam int FRAC_CNT_W      = 4;
  localparam int INT_W           = 31;
  localparam int FRAC_W          = 32;
  localparam int OQ_DEPTH        = 4;

  localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_OPEN       = 8'h28;
  localparam logic [7:0] CH_CLOSE      = 8'h29;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_FRAC  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    TK_FINAL   = 3'd0,
    TK_IDENT   = 3'd1,
    TK_INT     = 3'd2,
    TK_FLOAT   = 3'd3,
    TK_BRACKET = 3'd4,
    TK_OPER    = 3'd5
  } tok_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        token_type;
    logic [INT_W-1:0]  int_value;
    logic [FRAC_W-1:0] frac_value;
    logic [7:0]        symbol;
    logic              is_open_bracket;
    logic              ident_first;
    logic              overflowed;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    mode_t                 mode;
    logic [INT_W-1:0]      int_accum;
    logic [FRAC_W-1:0]     frac_accum;
    logic [FRAC_CNT_W-1:0] frac_cnt;
    logic                  sat;
  } lex_state_t;

  typedef struct packed {
    logic [1:0] n;
    out_beat_t  beat0;
    out_beat_t  beat1;
  } step_res_t;

  // round(10^-k * 2^32) for k = 1..9 at index k-1, zero for the rest
  function automatic logic [FRAC_W-1:0] pow10_q32(input logic [FRAC_CNT_W-1:0] idx);
    logic [FRAC_W-1:0] v;
    case (idx)
      4'd0:    v = 32'd429496730;
      4'd1:    v = 32'd42949673;
      4'd2:    v = 32'd4294967;
      4'd3:    v = 32'd429497;
      4'd4:    v = 32'd42950;
      4'd5:    v = 32'd4295;
      4'd6:    v = 32'd429;
      4'd7:    v = 32'd43;
      4'd8:    v = 32'd4;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic out_beat_t mk_beat(input tok_t tk, input logic [INT_W-1:0] ival,
                                        input logic [FRAC_W-1:0] frac, input logic [7:0] sym,
                                        input logic open, input logic first, input logic ovf);
    out_beat_t b;
    b.token_type      = tk;
    b.int_value       = ival;
    b.frac_value      = frac;
    b.symbol          = sym;
    b.is_open_bracket = open;
    b.ident_first     = first;
    b.overflowed      = ovf;
    b.last            = 1'b0;
    return b;
  endfunction

endpackage

[hdl/elx_step.sv]
// ----------------------------------------------------------------------------
// elx_step
// One lexer step: next scan state and up to two token beats per character.
// ----------------------------------------------------------------------------
module elx_step #(
  parameter int FRAC_DIGITS = elx_pkg::FRAC_DIGITS_DEF
) (
  input  elx_pkg::in_beat_t   item,
  input  elx_pkg::lex_state_t cur,
  output elx_pkg::lex_state_t nxt,
  output elx_pkg::step_res_t  res
);

  logic [7:0]                     c;
  logic                           is_sp;
  logic                           is_dig;
  logic                           is_let;
  logic [3:0]                     dig_val;
  logic [elx_pkg::INT_W+3:0]      int_mac;
  logic                           int_add_sat;
  logic [elx_pkg::INT_W-1:0]      int_add_val;
  logic [elx_pkg::FRAC_W+3:0]     frac_prod;
  logic [elx_pkg::FRAC_W+4:0]     frac_sum;
  logic [elx_pkg::FRAC_W-1:0]     frac_add_val;
  logic                           frac_room;
  elx_pkg::lex_state_t            st_state;
  logic                           st_emit;
  elx_pkg::out_beat_t             st_beat;
  logic                           pre_v;
  elx_pkg::out_beat_t             pre_b;
  logic                           use_start;
  logic                           fin;
  logic                           sec_v;
  elx_pkg::out_beat_t             sec_b;
  elx_pkg::lex_state_t            rst_state;

  // character classes and digit arithmetic
  always_comb begin
    c       = item.char_code;
    is_sp   = c inside {elx_pkg::CH_SPACE, [elx_pkg::CH_TAB:elx_pkg::CH_CR]};
    is_dig  = c inside {[elx_pkg::CH_ZERO:elx_pkg::CH_NINE]};
    is_let  = c inside {[elx_pkg::CH_UPPER_A:elx_pkg::CH_UPPER_Z],
                        [elx_pkg::CH_LOWER_A:elx_pkg::CH_LOWER_Z]};
    dig_val = 4'(c - elx_pkg::CH_ZERO);

    int_mac     = {4'd0, cur.int_accum} * (elx_pkg::INT_W+4)'(10)
                + (elx_pkg::INT_W+4)'(dig_val);
    int_add_sat = int_mac > (elx_pkg::INT_W+4)'(elx_pkg::INT_MAX);
    int_add_val = int_add_sat ? elx_pkg::INT_MAX : int_mac[elx_pkg::INT_W-1:0];

    frac_prod    = (elx_pkg::FRAC_W+4)'(dig_val)
                 * (elx_pkg::FRAC_W+4)'(elx_pkg::pow10_q32(cur.frac_cnt));
    frac_sum     = (elx_pkg::FRAC_W+5)'(cur.frac_accum) + (elx_pkg::FRAC_W+5)'(frac_prod);
    frac_add_val = (frac_sum[elx_pkg::FRAC_W+4:elx_pkg::FRAC_W] != '0) ?
                   {elx_pkg::FRAC_W{1'b1}} : frac_sum[elx_pkg::FRAC_W-1:0];
    frac_room    = 32'(cur.frac_cnt) < 32'(FRAC_DIGITS);
  end

  // character that opens a new token
  always_comb begin
    st_state      = cur;
    st_state.mode = elx_pkg::MODE_IDLE;
    st_emit       = 1'b0;
    st_beat       = '0;
    if (is_sp) begin
      st_emit = 1'b0;
    end else if (is_let || c == elx_pkg::CH_UNDERSCORE) begin
      st_state.mode = elx_pkg::MODE_IDENT;
      st_emit       = 1'b1;
      st_beat       = elx_pkg::mk_beat(elx_pkg::TK_IDENT, '0, '0, c, 1'b0, 1'b1, 1'b0);
    end else if (is_dig) begin
      st_state.mode       = elx_pkg::MODE_INT;
      st_state.int_accum  = elx_pkg::INT_W'(dig_val);
      st_state.frac_accum = '0;
      st_state.frac_cnt   = '0;
      st_state.sat        = 1'b0;
    end else if (c == elx_pkg::CH_DOT) begin
      st_state.mode       = elx_pkg::MODE_DOT;
      st_state.int_accum  = '0;
      st_state.frac_accum = '0;
      st_state.frac_cnt   = '0;
      st_state.sat        = 1'b0;
    end else if (c == elx_pkg::CH_OPEN || c == elx_pkg::CH_CLOSE) begin
      st_emit = 1'b1;
      st_beat = elx_pkg::mk_beat(elx_pkg::TK_BRACKET, '0, '0, 8'd0,
                                 c == elx_pkg::CH_OPEN, 1'b0, 1'b0);
    end else begin
      st_emit = 1'b1;
      st_beat = elx_pkg::mk_beat(elx_pkg::TK_OPER, '0, '0, c, 1'b0, 1'b0, 1'b0);
    end
  end

  // mode handling
  always_comb begin
    rst_state      = '0;
    rst_state.mode = elx_pkg::MODE_IDLE;
    nxt            = cur;
    pre_v          = 1'b0;
    pre_b          = '0;
    use_start      = 1'b0;
    fin            = 1'b0;
    if (item.end_of_input) begin
      fin = 1'b1;
      nxt = rst_state;
      case (cur.mode)
        elx_pkg::MODE_INT: begin
          pre_v = 1'b1;
          pre_b = elx_pkg::mk_beat(elx_pkg::TK_INT, cur.int_accum, '0, 8'd0,
                                   1'b0, 1'b0, cur.sat);
        end
        elx_pkg::MODE_FRAC: begin
          pre_v = 1'b1;
          pre_b = elx_pkg::mk_beat(elx_pkg::TK_FLOAT, cur.int_accum, cur.frac_accum,
                                   8'd0, 1'b0, 1'b0, cur.sat);
        end
        elx_pkg::MODE_DOT: begin
          pre_v = 1'b1;
          pre_b = elx_pkg::mk_beat(elx_pkg::TK_OPER, '0, '0, elx_pkg::CH_DOT,
                                   1'b0, 1'b0, 1'b0);
        end
        default: begin
          pre_v = 1'b0;
        end
      endcase
    end else begin
      case (cur.mode)
        elx_pkg::MODE_IDENT: begin
          if (is_let || is_dig || c == elx_pkg::CH_UNDERSCORE) begin
            pre_v = 1'b1;
            pre_b = elx_pkg::mk_beat(elx_pkg::TK_IDENT, '0, '0, c, 1'b0, 1'b0, 1'b0);
          end else begin
            use_start = 1'b1;
          end
        end
        elx_pkg::MODE_INT: begin
          if (is_dig) begin
            nxt.int_accum = int_add_val;
            nxt.sat       = cur.sat | int_add_sat;
          end else if (c == elx_pkg::CH_DOT) begin
            nxt.mode = elx_pkg::MODE_FRAC;
          end else begin
            pre_v     = 1'b1;
            pre_b     = elx_pkg::mk_beat(elx_pkg::TK_INT, cur.int_accum, '0, 8'd0,
                                         1'b0, 1'b0, cur.sat);
            use_start = 1'b1;
          end
        end
        elx_pkg::MODE_DOT: begin
          if (is_dig) begin
            nxt.mode = elx_pkg::MODE_FRAC;
            if (frac_room) begin
              nxt.frac_accum = frac_add_val;
              nxt.frac_cnt   = cur.frac_cnt + 4'd1;
            end
          end else begin
            pre_v     = 1'b1;
            pre_b     = elx_pkg::mk_beat(elx_pkg::TK_OPER, '0, '0, elx_pkg::CH_DOT,
                                         1'b0, 1'b0, 1'b0);
            use_start = 1'b1;
          end
        end
        elx_pkg::MODE_FRAC: begin
          if (is_dig) begin
            if (frac_room) begin
              nxt.frac_accum = frac_add_val;
              nxt.frac_cnt   = cur.frac_cnt + 4'd1;
            end
          end else begin
            pre_v     = 1'b1;
            pre_b     = elx_pkg::mk_beat(elx_pkg::TK_FLOAT, cur.int_accum, cur.frac_accum,
                                         8'd0, 1'b0, 1'b0, cur.sat);
            use_start = 1'b1;
          end
        end
        default: begin
          use_start = 1'b1;
        end
      endcase
      if (use_start) begin
        nxt = st_state;
      end
    end
  end

  // pack the beats, last flag on the final one
  always_comb begin
    sec_v = 1'b0;
    sec_b = '0;
    res   = '0;
    if (fin) begin
      sec_v = 1'b1;
      sec_b = elx_pkg::mk_beat(elx_pkg::TK_FINAL, '0, '0, 8'd0, 1'b0, 1'b0, 1'b0);
    end else if (use_start && st_emit) begin
      sec_v = 1'b1;
      sec_b = st_beat;
    end
    if (pre_v && sec_v) begin
      res.n          = 2'd2;
      res.beat0      = pre_b;
      res.beat1      = sec_b;
      res.beat1.last = 1'b1;
    end else if (pre_v) begin
      res.n          = 2'd1;
      res.beat0      = pre_b;
      res.beat0.last = 1'b1;
    end else if (sec_v) begin
      res.n          = 2'd1;
      res.beat0      = sec_b;
      res.beat0.last = 1'b1;
    end
  end

endmodule

[hdl/elx_outq.sv]
// ----------------------------------------------------------------------------
// elx_outq
// Token queue: takes up to two beats per cycle, gives one per handshake.
// ----------------------------------------------------------------------------
module elx_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  elx_pkg::step_res_t   push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output elx_pkg::out_beat_t   out_data
);

  localparam int PTR_W = $clog2(elx_pkg::OQ_DEPTH);
  localparam int CNT_W = $clog2(elx_pkg::OQ_DEPTH + 1);

  elx_pkg::out_beat_t mem [elx_pkg::OQ_DEPTH];

  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] wr_nxt;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W-1:0] rd_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [1:0]       n_push;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = mem[rd_r];
  assign room      = cnt_r <= CNT_W'(elx_pkg::OQ_DEPTH - 2);

  always_comb begin
    n_push  = push_en ? push.n : 2'd0;
    wr_nxt  = wr_r + PTR_W'(n_push);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_r] <= push.beat0;
    end
    if (n_push == 2'd2) begin
      mem[wr_r + PTR_W'(1)] <= push.beat1;
    end
  end

endmodule

[hdl/expression_lexer.sv]
// ----------------------------------------------------------------------------
// expression_lexer
// Arithmetic expression tokenizer, one character beat in, token beats out.
// ----------------------------------------------------------------------------
// in_valid/in_ready carry one character or an end-of-input mark per beat.
// out_valid/out_ready carry token beats; a character causes zero, one or
// two tokens and the last token of each character has last set.
// A beat is held in the input register, then the lexer step writes its
// tokens into a four-entry token queue, from which they are taken.
// One character per cycle is sustained while each character gives at most
// one token and the receiver does not stall; a character that closes a
// number and opens another token gives two tokens, which leave the queue
// one per handshake. The rate is set by the single read port of the queue.
// Reset empties the input register and queue and returns the scanner to
// idle with the number accumulators cleared.
// When the receiver stalls, the queue fills; the lexer step waits until two
// entries are free and in_ready drops once the input register is held.
// FRAC_DIGITS sets how many fraction digits count toward a float.
// ----------------------------------------------------------------------------
module expression_lexer #(
  parameter int FRAC_DIGITS = elx_pkg::FRAC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  elx_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output elx_pkg::out_beat_t out_data
);

  logic                in_vld_r;
  elx_pkg::in_beat_t   in_beat_r;
  elx_pkg::lex_state_t state_r;
  elx_pkg::lex_state_t state_nxt;
  elx_pkg::step_res_t  step_res;
  logic                room;
  logic                fire;

  assign fire     = in_vld_r && room;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_beat_r <= in_data;
    end
  end

  // all-zero state is idle with cleared accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  elx_step #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_step (
    .item (in_beat_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  elx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
